>>> src/descendant_count_estimate_macros.svh
// ----------------------------------------------------------------------------
// descendant_count_estimate_macros.svh
// Assertion shorthands for the descendant count estimator.
// ----------------------------------------------------------------------------
`ifndef DESCENDANT_COUNT_ESTIMATE_MACROS_SVH
`define DESCENDANT_COUNT_ESTIMATE_MACROS_SVH

// same-cycle implication, checked out of reset
`define DCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dce_pkg.sv
// ----------------------------------------------------------------------------
// dce_pkg
// Shared widths, register map, inter-stage structs and the output clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dce_pkg;

  localparam int SampleHalf = 100;
  localparam int SampleSpan = 2 * SampleHalf;

  localparam int CntW   = 31;
  localparam int PreW   = 31;
  localparam int DepthW = 7;
  localparam int EstW   = 32;
  localparam int SumW   = 48;
  localparam int TermW  = PreW + 2;
  localparam int DataW  = 32;
  localparam int AddrW  = 3;

  // remainder width of the divide by the sample span
  localparam int RemW    = $clog2(SampleSpan);
  // product kept to this signed width; beyond it the estimate saturates anyway
  localparam int PclW    = EstW + RemW + 1;
  localparam int DvdW    = PclW;

  // divide by span in two digits: high digit, then its remainder joined
  // with the low digit
  localparam int DigW   = 20;
  localparam int HiW    = DvdW - DigW;
  localparam int DivInW = RemW + DigW;
  localparam int RcpSh  = DivInW + RemW;
  // ceil(2^RcpSh / span): exact floor division for any input below 2^DivInW
  localparam longint RcpVal = ((longint'(1) <<< RcpSh) + longint'(SampleSpan) - 1) /
                              longint'(SampleSpan);

  localparam logic RegCtxCount = 1'b0;
  localparam logic RegDocCount = 1'b1;

  typedef struct packed {
    logic [CntW-1:0] ctx_count;
    logic [CntW-1:0] doc_count;
  } cfg_t;

  typedef struct packed {
    logic [PreW-1:0]         pre;
    logic [PreW-1:0]         post;
    logic signed [TermW-1:0] term;
    logic                    counted;
    logic                    last;
    logic                    sampled;
  } a_item_t;

  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic                   sampled;
  } b_res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } scl_stat_t;

  // limit to doc_count - 1 from above and to the 32-bit minimum from below
  function automatic logic signed [EstW-1:0] clamp_est(
    input logic signed [SumW-1:0] v,
    input logic [CntW-1:0]        doc
  );
    logic signed [SumW-1:0] lim;
    logic signed [SumW-1:0] lo;
    lim = $signed(SumW'(doc) - SumW'(1));
    lo  = {{(SumW-EstW+1){1'b1}}, {(EstW-1){1'b0}}};
    if (v > lim) begin
      clamp_est = lim[EstW-1:0];
    end else if (v < lo) begin
      clamp_est = lo[EstW-1:0];
    end else begin
      clamp_est = v[EstW-1:0];
    end
  endfunction

endpackage

>>> src/dce_regs.sv
// ----------------------------------------------------------------------------
// dce_regs
// APB-style register file: context count and document node count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dce_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dce_pkg::AddrW-1:0]  paddr,
  input  logic [dce_pkg::DataW-1:0]  pwdata,
  output logic [dce_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output dce_pkg::cfg_t              cfg
);
  import dce_pkg::*;

  logic [CntW-1:0] ctx_r, ctx_nxt;
  logic [CntW-1:0] doc_r, doc_nxt;
  logic            wr;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_sel = paddr[AddrW-1];

  always_comb begin
    ctx_nxt = ctx_r;
    doc_nxt = doc_r;
    if (wr) begin
      case (reg_sel)
        RegCtxCount: ctx_nxt = pwdata[CntW-1:0];
        RegDocCount: doc_nxt = pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
      doc_r <= CntW'(1);
    end else begin
      ctx_r <= ctx_nxt;
      doc_r <= doc_nxt;
    end
  end

  assign prdata = (reg_sel == RegDocCount) ? DataW'(doc_r) : DataW'(ctx_r);

  assign cfg.ctx_count = ctx_r;
  assign cfg.doc_count = doc_r;

endmodule

>>> src/dce_front.sv
// ----------------------------------------------------------------------------
// dce_front
// Input register: position tracking, sampling window and term precompute.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dce_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        accept,
  input  logic [dce_pkg::PreW-1:0]    node_pre,
  input  logic [dce_pkg::PreW-1:0]    node_post,
  input  logic [dce_pkg::DepthW-1:0]  node_depth,
  input  logic [dce_pkg::CntW-1:0]    ctx_count,
  output logic                        a_vld,
  output dce_pkg::a_item_t            a_item
);
  import dce_pkg::*;

  logic [CntW-1:0] pos_r, pos_nxt;
  logic            a_vld_r, a_vld_nxt;
  a_item_t         a_item_r, a_item_nxt;
  logic            take;
  logic            last;
  logic            sampled;
  logic            counted;

  always_comb begin
    // empty context: items are dropped
    take    = accept && (ctx_count != '0);
    last    = ({1'b0, pos_r} + (CntW+1)'(1)) >= {1'b0, ctx_count};
    sampled = ctx_count > CntW'(SampleSpan);
    counted = !sampled || (pos_r < CntW'(SampleHalf)) ||
              (pos_r >= ctx_count - CntW'(SampleHalf));

    a_item_nxt.pre     = node_pre;
    a_item_nxt.post    = node_post;
    a_item_nxt.term    = $signed(TermW'({2'b00, node_post}) - TermW'({2'b00, node_pre}) +
                                 TermW'(node_depth) - TermW'(1));
    a_item_nxt.counted = counted;
    a_item_nxt.last    = last;
    a_item_nxt.sampled = sampled;

    pos_nxt = pos_r;
    if (take) begin
      pos_nxt = last ? '0 : pos_r + CntW'(1);
    end
    a_vld_nxt = en ? take : a_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      a_vld_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      a_vld_r <= a_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && take) begin
      a_item_r <= a_item_nxt;
    end
  end

  assign a_vld  = a_vld_r;
  assign a_item = a_item_r;

endmodule

>>> src/dce_accum.sv
// ----------------------------------------------------------------------------
// dce_accum
// Running maximum and saturating sum; hands the final sum of a run onward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dce_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              a_vld,
  input  dce_pkg::a_item_t  a_item,
  output logic              b_vld,
  output dce_pkg::b_res_t   b_res
);
  import dce_pkg::*;

  logic [PreW-1:0]        lp_r, lp_nxt;
  logic signed [SumW-1:0] sum_r, sum_nxt;
  logic                   b_vld_r, b_vld_nxt;
  b_res_t                 b_res_r, b_res_nxt;
  logic                   upd;
  logic [SumW:0]          add;
  logic signed [SumW-1:0] sat;
  logic signed [SumW-1:0] sum_upd;

  always_comb begin
    upd = a_item.counted && (a_item.pre > lp_r) && (a_item.post > lp_r);
    add = {sum_r[SumW-1], sum_r} + (SumW+1)'(a_item.term);
    if (add[SumW] != add[SumW-1]) begin
      sat = add[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sat = add[SumW-1:0];
    end
    sum_upd = upd ? sat : sum_r;

    lp_nxt            = lp_r;
    sum_nxt           = sum_r;
    b_res_nxt.sum     = sum_upd;
    b_res_nxt.sampled = a_item.sampled;
    if (en && a_vld) begin
      if (a_item.last) begin
        lp_nxt  = '0;
        sum_nxt = '0;
      end else begin
        lp_nxt  = upd ? a_item.post : lp_r;
        sum_nxt = sum_upd;
      end
    end
    b_vld_nxt = en ? (a_vld && a_item.last) : b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r    <= '0;
      sum_r   <= '0;
      b_vld_r <= 1'b0;
    end else begin
      lp_r    <= lp_nxt;
      sum_r   <= sum_nxt;
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && a_vld && a_item.last) begin
      b_res_r <= b_res_nxt;
    end
  end

  assign b_vld = b_vld_r;
  assign b_res = b_res_r;

endmodule

>>> src/dce_scale.sv
// ----------------------------------------------------------------------------
// dce_scale
// floor(sum * count / span): one multiply, then a divide by span in two digit
// steps by reciprocal multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dce_scale (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             take,
  input  logic signed [dce_pkg::SumW-1:0]  sum,
  input  logic [dce_pkg::CntW-1:0]         n,
  output dce_pkg::scl_stat_t               stat,
  output logic signed [dce_pkg::SumW-1:0]  q
);
  import dce_pkg::*;

  typedef enum logic [5:0] {
    ScIdle = 6'b000001,
    ScMul  = 6'b000010,
    ScPrep = 6'b000100,
    ScHi   = 6'b001000,
    ScLo   = 6'b010000,
    ScDone = 6'b100000
  } sc_state_t;

  localparam logic signed [2*EstW-1:0] PHi = {{(2*EstW-PclW+1){1'b0}}, {(PclW-1){1'b1}}};
  localparam logic signed [2*EstW-1:0] PLo = {{(2*EstW-PclW+1){1'b1}}, {(PclW-1){1'b0}}};

  sc_state_t                 st_r, st_nxt;
  logic signed [EstW-1:0]    s_r, s_nxt;
  logic signed [2*EstW-1:0]  p_r, p_nxt;
  logic [DvdW-1:0]           dvd_r, dvd_nxt;
  logic [RemW-1:0]           rem_r, rem_nxt;
  logic [HiW-1:0]            hq_r, hq_nxt;
  logic                      neg_r, neg_nxt;

  logic signed [EstW-1:0]    s_sat;
  logic signed [EstW-1:0]    n_s;
  logic signed [2*EstW-1:0]  prod;
  logic signed [PclW-1:0]    pc;
  logic [PclW:0]             negx;
  logic [DvdW-1:0]           mag;
  logic [DivInW-1:0]         dv_in;
  logic [2*DivInW:0]         dv_prod;
  logic [DivInW-1:0]         dv_q;
  logic [RemW-1:0]           dv_r;
  logic [SumW-1:0]           qmag;

  always_comb begin
    // sums beyond 32 bits already push the estimate past any clamp bound
    if (sum > $signed(SumW'({1'b0, {(EstW-1){1'b1}}}))) begin
      s_sat = {1'b0, {(EstW-1){1'b1}}};
    end else if (sum < $signed({{(SumW-EstW+1){1'b1}}, {(EstW-1){1'b0}}})) begin
      s_sat = {1'b1, {(EstW-1){1'b0}}};
    end else begin
      s_sat = sum[EstW-1:0];
    end

    n_s  = $signed({1'b0, n});
    prod = s_r * n_s;

    if (p_r > PHi) begin
      pc = PHi[PclW-1:0];
    end else if (p_r < PLo) begin
      pc = PLo[PclW-1:0];
    end else begin
      pc = p_r[PclW-1:0];
    end
    // floor for negatives: -((|p| + span - 1) / span)
    negx = (PclW+1)'(0) - {pc[PclW-1], pc} + (PclW+1)'(SampleSpan - 1);
    mag  = pc[PclW-1] ? negx[DvdW-1:0] : pc[DvdW-1:0];

    // high digit alone first, then its remainder in front of the low digit
    dv_in   = (st_r == ScHi) ? DivInW'(dvd_r[DvdW-1:DigW]) : {rem_r, dvd_r[DigW-1:0]};
    dv_prod = (2*DivInW+1)'(dv_in) * (2*DivInW+1)'(RcpVal);
    dv_q    = DivInW'(dv_prod >> RcpSh);
    dv_r    = RemW'(dv_in - dv_q * DivInW'(SampleSpan));

    qmag = SumW'(dvd_r);
    q    = neg_r ? $signed(SumW'(0) - qmag) : $signed(qmag);
  end

  always_comb begin
    st_nxt  = st_r;
    s_nxt   = s_r;
    p_nxt   = p_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    hq_nxt  = hq_r;
    neg_nxt = neg_r;
    case (st_r)
      ScIdle: begin
        if (start) begin
          s_nxt  = s_sat;
          st_nxt = ScMul;
        end
      end
      ScMul: begin
        p_nxt  = prod;
        st_nxt = ScPrep;
      end
      ScPrep: begin
        neg_nxt = pc[PclW-1];
        dvd_nxt = mag;
        st_nxt  = ScHi;
      end
      ScHi: begin
        hq_nxt  = HiW'(dv_q);
        rem_nxt = dv_r;
        st_nxt  = ScLo;
      end
      ScLo: begin
        dvd_nxt = {hq_r, DigW'(dv_q)};
        st_nxt  = ScDone;
      end
      ScDone: begin
        if (take) begin
          st_nxt = ScIdle;
        end
      end
      default: st_nxt = ScIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ScIdle;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    p_r   <= p_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    hq_r  <= hq_nxt;
    neg_r <= neg_nxt;
  end

  assign stat.idle = (st_r == ScIdle);
  assign stat.done = (st_r == ScDone);

endmodule

>>> src/descendant_count_estimate.sv
// ----------------------------------------------------------------------------
// descendant_count_estimate
// Path: an unsampled run's result passes the front, accumulator and output
//   registers once its last request is taken; a sampled run (count above twice
//   SampleHalf) also passes dce_scale's multiply and two-digit reciprocal divide.
// Throughput: one request per cycle; only a final request held behind a busy
//   scaler or a stalled output stalls the input.
// Reset: synchronous, active low; clears run state, count 0, doc count 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "descendant_count_estimate_macros.svh"

module descendant_count_estimate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dce_pkg::AddrW-1:0]   paddr,
  input  logic [dce_pkg::DataW-1:0]   pwdata,
  output logic [dce_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dce_pkg::PreW-1:0]    in_node_pre,
  input  logic [dce_pkg::PreW-1:0]    in_node_post,
  input  logic [dce_pkg::DepthW-1:0]  in_node_depth,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [dce_pkg::EstW-1:0] out_estimate
);
  import dce_pkg::*;

  cfg_t                   cfg;
  a_item_t                a_item;
  logic                   a_vld;
  b_res_t                 b_res;
  logic                   b_vld;
  scl_stat_t              scl_stat;
  logic signed [SumW-1:0] scl_q;

  logic                   en;
  logic                   accept;
  logic                   out_free;
  logic                   scl_take;
  logic                   b_direct;
  logic                   b_to_scl;
  logic                   out_vld_r, out_vld_nxt;
  logic signed [EstW-1:0] out_est_r, out_est_nxt;

  dce_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dce_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .accept     (accept),
    .node_pre   (in_node_pre),
    .node_post  (in_node_post),
    .node_depth (in_node_depth),
    .ctx_count  (cfg.ctx_count),
    .a_vld      (a_vld),
    .a_item     (a_item)
  );

  dce_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .a_vld  (a_vld),
    .a_item (a_item),
    .b_vld  (b_vld),
    .b_res  (b_res)
  );

  dce_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (b_to_scl),
    .take  (scl_take),
    .sum   (b_res.sum),
    .n     (cfg.ctx_count),
    .stat  (scl_stat),
    .q     (scl_q)
  );

  // a finished run waits in the accumulator stage until it can move on
  always_comb begin
    out_free = !out_vld_r || !out_stall;
    scl_take = scl_stat.done && out_free;
    b_direct = b_vld && !b_res.sampled && out_free && !scl_stat.done;
    b_to_scl = b_vld && b_res.sampled && scl_stat.idle;
    en       = !b_vld || b_direct || b_to_scl;
    accept   = in_valid && en;

    out_vld_nxt = (scl_take || b_direct) ? 1'b1 : (out_vld_r && out_stall);
    out_est_nxt = clamp_est(scl_take ? scl_q : b_res.sum, cfg.doc_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (scl_take || b_direct) begin
      out_est_r <= out_est_nxt;
    end
  end

  assign in_stall     = !en;
  assign out_valid    = out_vld_r;
  assign out_estimate = out_est_r;

  `DCE_ASSERT_IMP(a_stall_src, in_stall, b_vld, "input stalled without a held final sum")
  `DCE_ASSERT_IMP(a_out_src, $rose(out_vld_r), $past(scl_take || b_direct), "result from nowhere")
  `DCE_ASSERT_NXT(a_scl_start, b_vld && b_res.sampled && en, !scl_stat.idle, "scaler not started")

endmodule
